// ----- sv/nccb_pkg.sv -----
// Shared types, command codes and CRC/record helpers for the nonce counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nccb_pkg;

  localparam int PREFIX_W = 24;
  localparam int LOW_W    = 24;
  localparam int REC_W    = 64;
  localparam int CTR_W    = PREFIX_W + LOW_W;

  localparam logic [7:0]          CRC_POLY   = 8'h07;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX = {PREFIX_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_REQ    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RESEED = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [REC_W-1:0]    raw_record;
    logic [PREFIX_W-1:0] prefix_noise;
    logic [LOW_W-1:0]    low_noise;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [CTR_W-1:0] counter;
    logic [REC_W-1:0] raw_out;
    logic             raw_write;
  } res_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] d);
    logic [7:0] c;
    c = crc_in ^ d;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_prefix(input logic [PREFIX_W-1:0] p);
    logic [7:0] c;
    c = crc_byte(8'h00, p[23:16]);
    c = crc_byte(c, p[15:8]);
    c = crc_byte(c, p[7:0]);
    return c;
  endfunction

  // copy passes when CRC matches and prefix is not all ones
  function automatic logic copy_ok(input logic [31:0] half);
    return (crc_prefix(half[31:8]) == half[7:0]) && (half[31:8] != PREFIX_MAX);
  endfunction

  function automatic logic [REC_W-1:0] build_record(input logic [PREFIX_W-1:0] p);
    logic [31:0] half;
    half = {p, crc_prefix(p)};
    return {half, half};
  endfunction

  // top byte folded to a nibble: b[3:0] ^ b[7:4]
  function automatic logic [23:0] mask_top(input logic [23:0] v);
    return {4'h0, v[23:20] ^ v[19:16], v[15:0]};
  endfunction

  function automatic logic [PREFIX_W-1:0] reseed_val(input logic [PREFIX_W-1:0] noise);
    logic [PREFIX_W-1:0] p;
    p = mask_top(noise);
    if (p[23:8] == 16'h0000) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/nonce_counter_with_crc_backup_top.sv -----
// Top level of the 48-bit nonce counter with CRC-protected prefix record.
// Depends on nccb_pkg, nccb_in_stage, nccb_core, nccb_out_stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_ready  | cmd, raw_record, prefix_noise, low_noise
//  out_    | output    | out_valid / out_ready| ok, counter, raw_out, raw_write
//
// One transfer per cycle sustained while out_ready stays high; an item passes
// through the input register, then the result register.
// The record decode, increment and CRC rebuild are one pass of logic
// between those registers, which also updates the counter state.
// Synchronous active-low reset clears the state to a zero record, zero
// ephemeral part and no request seen; no clearing pass is needed.
// A stalled result holds the result register; the input register still
// drains into it the moment out_ready frees it.
`timescale 1ns / 1ps
`default_nettype none

module nonce_counter_with_crc_backup_top
  import nccb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [REC_W-1:0]    in_raw_record,
  input  wire logic [PREFIX_W-1:0] in_prefix_noise,
  input  wire logic [LOW_W-1:0]    in_low_noise,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_ok,
  output logic [CTR_W-1:0]         out_counter,
  output logic [REC_W-1:0]         out_raw_out,
  output logic                     out_raw_write
);

  item_t in_item, s_item;
  logic  s_valid, can_load, advance;
  res_t  core_res, res_q;

  assign in_item.cmd          = in_cmd;
  assign in_item.raw_record   = in_raw_record;
  assign in_item.prefix_noise = in_prefix_noise;
  assign in_item.low_noise    = in_low_noise;

  // an item leaves the input register, updates state and lands in the
  // result register in the same cycle
  assign advance = s_valid && can_load;

  nccb_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  nccb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s_item),
    .res     (core_res)
  );

  nccb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (core_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_ok        = res_q.ok;
  assign out_counter   = res_q.counter;
  assign out_raw_out   = res_q.raw_out;
  assign out_raw_write = res_q.raw_write;

endmodule

`default_nettype wire

// ----- sv/nccb_in_stage.sv -----
// Input register stage: captures one item per transfer.
// Depends on nccb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nccb_in_stage
  import nccb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       s_valid,
  output item_t      s_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

`default_nettype wire

// ----- sv/nccb_core.sv -----
// Counter state and single-pass next-state logic: record decode, reseed,
// increment and record rebuild. Depends on nccb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nccb_core
  import nccb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  advance,
  input  wire item_t item,
  output res_t       res
);

  logic [REC_W-1:0]    rec_r, rec_nxt;
  logic [LOW_W-1:0]    low_r, low_nxt;
  logic                started_r, started_nxt;

  logic                pri_ok, sec_ok, rd_ok;
  logic [PREFIX_W-1:0] p0, p_inc, seed;
  logic [REC_W-1:0]    inc_rec, seed_rec;
  logic                inc_ok;
  logic [LOW_W-1:0]    low_first, low_inc;
  logic                ok;
  logic [CTR_W-1:0]    ctr;
  logic                wr;

  // current record decode; primary copy preferred
  assign pri_ok = copy_ok(rec_r[63:32]);
  assign sec_ok = copy_ok(rec_r[31:0]);
  assign rd_ok  = pri_ok || sec_ok;
  assign p0     = pri_ok ? rec_r[63:40] : rec_r[31:8];

  assign p_inc    = p0 + PREFIX_W'(1);
  assign inc_rec  = build_record(p_inc);
  assign inc_ok   = (p_inc != PREFIX_MAX);
  assign seed     = reseed_val(item.prefix_noise);
  assign seed_rec = build_record(seed);

  assign low_first = mask_top(item.low_noise) + LOW_W'(1);
  assign low_inc   = low_r + LOW_W'(1);

  always_comb begin
    rec_nxt     = rec_r;
    low_nxt     = low_r;
    started_nxt = started_r;
    ok          = 1'b1;
    ctr         = '0;
    wr          = 1'b0;
    unique case (cmd_t'(item.cmd))
      CMD_LOAD: begin
        rec_nxt = ~item.raw_record;
      end
      CMD_CLEAR: begin
        rec_nxt = '0;
        wr      = 1'b1;
      end
      CMD_RESEED: begin
        rec_nxt = seed_rec;
        wr      = 1'b1;
      end
      CMD_REQ: begin
        started_nxt = 1'b1;
        if (!started_r) begin
          if (!rd_ok) begin
            ok = 1'b0;
          end else if (p0 == '0) begin
            // masked seed cannot wrap, so no prefix bump here
            rec_nxt = seed_rec;
            wr      = 1'b1;
            low_nxt = low_first;
            ctr     = {seed, low_first};
          end else begin
            low_nxt = low_first;
            rec_nxt = inc_rec;
            wr      = 1'b1;
            ok      = inc_ok;
            ctr     = inc_ok ? {p_inc, low_first} : '0;
          end
        end else begin
          low_nxt = low_inc;
          if (low_inc == '0) begin
            if (!rd_ok) begin
              ok = 1'b0;
            end else begin
              rec_nxt = inc_rec;
              wr      = 1'b1;
              ok      = inc_ok;
              ctr     = inc_ok ? {p_inc, low_inc} : '0;
            end
          end else begin
            ok  = rd_ok;
            ctr = rd_ok ? {p0, low_inc} : '0;
          end
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r     <= '0;
      low_r     <= '0;
      started_r <= 1'b0;
    end else if (advance) begin
      rec_r     <= rec_nxt;
      low_r     <= low_nxt;
      started_r <= started_nxt;
    end
  end

  assign res.ok        = ok;
  assign res.counter   = ctr;
  assign res.raw_out   = ~rec_nxt;
  assign res.raw_write = wr;

endmodule

`default_nettype wire

// ----- sv/nccb_out_stage.sv -----
// Result register: holds one result until the consumer takes the transfer.
// Depends on nccb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nccb_out_stage
  import nccb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

// ----- tb/nonce_counter_with_crc_backup_top_tb.sv -----
// Self-checking testbench for the 48-bit nonce counter with CRC-protected prefix record.
// Depends on nccb_pkg and nonce_counter_with_crc_backup_top; a directed table then
// random traffic, every result checked against an in-bench predictor or a typed-in row.
`timescale 1ns / 1ps
`default_nettype none

module nonce_counter_with_crc_backup_top_tb;
  import nccb_pkg::*;

  localparam int RAND_ITEMS   = 630;
  localparam int STALL_LIMIT  = 1000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES  = 48;    // long receiver hold-off, well past the block's buffering
  localparam int DRAIN_CYCLES = 8;     // extra idle time after the last result is checked

  // One stimulus row. Where "fixed" is set the expected result is typed into the table
  // rather than taken from the predictor.
  typedef struct packed {
    cmd_t                cmd;
    logic [REC_W-1:0]    raw;
    logic [PREFIX_W-1:0] pnoise;
    logic [LOW_W-1:0]    lnoise;
    logic                fixed;
    res_t                want;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PATTERN
  } rx_mode_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [1:0]          in_cmd          = CMD_LOAD;
  logic [REC_W-1:0]    in_raw_record   = '0;
  logic [PREFIX_W-1:0] in_prefix_noise = '0;
  logic [LOW_W-1:0]    in_low_noise    = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic                out_ok;
  logic [CTR_W-1:0]    out_counter;
  logic [REC_W-1:0]    out_raw_out;
  logic                out_raw_write;

  // Predictor state: decoded record, ephemeral part, request-seen flag
  logic [REC_W-1:0] rec_shadow = '0;
  logic [LOW_W-1:0] low_shadow = '0;
  logic             req_seen   = 1'b0;

  res_t      due_results[$];
  stim_row_t dir_tab[$];

  int  errors    = 0;
  int  n_in      = 0;
  int  n_req     = 0;
  int  n_checked = 0;
  int  n_fail    = 0;
  int  n_wb      = 0;
  bit  hold_req  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nonce_counter_with_crc_backup_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_raw_record   (in_raw_record),
    .in_prefix_noise (in_prefix_noise),
    .in_low_noise    (in_low_noise),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_counter     (out_counter),
    .out_raw_out     (out_raw_out),
    .out_raw_write   (out_raw_write)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // CRC-8 over the 24 prefix bits, one bit at a time, MSB first, init 0
  function automatic logic [7:0] prefix_crc8(input logic [PREFIX_W-1:0] p);
    logic [7:0] c;
    logic       fb;
    c = 8'h00;
    for (int i = PREFIX_W - 1; i >= 0; i--) begin
      fb = c[7] ^ p[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] copy_of(input logic [PREFIX_W-1:0] p);
    return {p, prefix_crc8(p)};
  endfunction

  function automatic logic [REC_W-1:0] record_of(input logic [PREFIX_W-1:0] p);
    return {copy_of(p), copy_of(p)};
  endfunction

  // a copy is usable when its CRC holds and the prefix is not all ones
  function automatic logic copy_usable(input logic [31:0] h);
    return (prefix_crc8(h[31:8]) == h[7:0]) && (h[31:8] != PREFIX_MAX);
  endfunction

  // primary copy first, then secondary
  function automatic logic read_shadow(output logic [PREFIX_W-1:0] p);
    p = '0;
    if (copy_usable(rec_shadow[63:32])) begin
      p = rec_shadow[63:40];
      return 1'b1;
    end
    if (copy_usable(rec_shadow[31:0])) begin
      p = rec_shadow[31:8];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // top byte collapses to the XOR of its two nibbles
  function automatic logic [23:0] fold_top(input logic [23:0] v);
    return {4'h0, v[23:20] ^ v[19:16], v[15:0]};
  endfunction

  // a seeded prefix is never zero in its top two bytes without its lsb set
  function automatic logic [PREFIX_W-1:0] seeded_prefix(input logic [PREFIX_W-1:0] noise);
    logic [PREFIX_W-1:0] p;
    p = fold_top(noise);
    if (p[23:8] == 16'h0000) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

  // Advances the shadow state by one item and returns the result it should give
  function automatic res_t next_nonce(input stim_row_t r);
    res_t                res;
    logic [PREFIX_W-1:0] p;
    logic                first;
    logic                bump;
    res.ok        = 1'b1;
    res.counter   = '0;
    res.raw_write = 1'b0;
    p             = '0;
    case (r.cmd)
      CMD_LOAD: begin
        rec_shadow = ~r.raw;
      end
      CMD_CLEAR: begin
        rec_shadow    = '0;
        res.raw_write = 1'b1;
      end
      CMD_RESEED: begin
        rec_shadow    = record_of(seeded_prefix(r.pnoise));
        res.raw_write = 1'b1;
      end
      CMD_REQ: begin
        first    = !req_seen;
        bump     = 1'b0;
        req_seen = 1'b1;
        if (first) begin
          if (!read_shadow(p)) begin
            res.ok = 1'b0;
          end else if (p == '0) begin
            rec_shadow    = record_of(seeded_prefix(r.pnoise));
            res.raw_write = 1'b1;
          end else begin
            bump = 1'b1;
          end
        end
        if (res.ok) begin
          if (first) begin
            low_shadow = fold_top(r.lnoise);
          end
          low_shadow = low_shadow + LOW_W'(1);
          if (low_shadow == '0) begin
            bump = 1'b1;
          end
          if (bump) begin
            if (!read_shadow(p) || p == PREFIX_MAX) begin
              res.ok = 1'b0;
            end else begin
              rec_shadow    = record_of(p + PREFIX_W'(1));
              res.raw_write = 1'b1;
            end
          end
          if (res.ok) begin
            if (read_shadow(p)) begin
              res.counter = {p, low_shadow};
            end else begin
              res.ok = 1'b0;
            end
          end
        end
      end
    endcase
    res.raw_out = ~rec_shadow;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic res_t mk_res(input logic ok, input logic [CTR_W-1:0] ctr,
                                  input logic [REC_W-1:0] raw, input logic wr);
    res_t r;
    r.ok        = ok;
    r.counter   = ctr;
    r.raw_out   = raw;
    r.raw_write = wr;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input cmd_t c, input logic [REC_W-1:0] raw,
                                       input logic [PREFIX_W-1:0] pn,
                                       input logic [LOW_W-1:0] ln,
                                       input logic fixed, input res_t want);
    stim_row_t r;
    r.cmd    = c;
    r.raw    = raw;
    r.pnoise = pn;
    r.lnoise = ln;
    r.fixed  = fixed;
    r.want   = want;
    return r;
  endfunction

  // prefixes biased towards the interesting corners
  function automatic logic [PREFIX_W-1:0] pick_prefix();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'h000001;
      2:       return 24'hfffffe;
      3:       return 24'hffffff;
      4:       return 24'h7fffff;
      default: return w[23:0];
    endcase
  endfunction

  // Mostly counter requests on well-formed records; the rest loads (some with a
  // damaged copy or pure noise), reseeds and clears.
  function automatic stim_row_t random_row();
    stim_row_t           r;
    logic [PREFIX_W-1:0] pa;
    logic [PREFIX_W-1:0] pb;
    logic [REC_W-1:0]    rec;
    logic [31:0]         w;
    int                  pick;
    r.fixed  = 1'b0;
    r.want   = '0;
    r.raw    = {$urandom, $urandom};
    w        = $urandom;
    r.pnoise = w[23:0];
    w        = $urandom;
    r.lnoise = w[23:0];
    pick     = $urandom_range(0, 99);
    if (pick < 58) begin
      r.cmd = CMD_REQ;
    end else if (pick < 80) begin
      r.cmd = CMD_LOAD;
      pa    = pick_prefix();
      pb    = ($urandom_range(0, 2) == 0) ? pick_prefix() : pa;
      rec   = {copy_of(pa), copy_of(pb)};
      if ($urandom_range(0, 3) == 0) begin
        rec = rec ^ (64'd1 << $urandom_range(0, 63));
      end
      r.raw = ~rec;
    end else if (pick < 86) begin
      r.cmd = CMD_LOAD;
    end else if (pick < 94) begin
      r.cmd = CMD_RESEED;
    end else begin
      r.cmd = CMD_CLEAR;
    end
    return r;
  endfunction

  // Present one item from the falling edge, hold it until the transfer, then
  // queue what it should produce.
  task automatic offer(input stim_row_t r);
    res_t guess;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_cmd          <= r.cmd;
    in_raw_record   <= r.raw;
    in_prefix_noise <= r.pnoise;
    in_low_noise    <= r.lnoise;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    guess = next_nonce(r);
    due_results.push_back(r.fixed ? r.want : guess);
    n_in++;
    if (r.cmd == CMD_REQ) begin
      n_req++;
    end
  endtask

  task automatic rest(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t head;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got ok=%b counter=%h raw=%h write=%b",
                 $time, out_ok, out_counter, out_raw_out, out_raw_write);
      end else begin
        head = due_results.pop_front();
        n_checked++;
        if (!head.ok) begin
          n_fail++;
        end
        if (head.raw_write) begin
          n_wb++;
        end
        if (out_ok !== head.ok) begin
          flag_mismatch("ok", 64'(head.ok), 64'(out_ok));
        end
        if (out_counter !== head.counter) begin
          flag_mismatch("counter", 64'(head.counter), 64'(out_counter));
        end
        if (out_raw_out !== head.raw_out) begin
          flag_mismatch("raw_out", head.raw_out, out_raw_out);
        end
        if (out_raw_write !== head.raw_write) begin
          flag_mismatch("raw_write", 64'(head.raw_write), 64'(out_raw_write));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: phases of free running, coin-toss stalls and a rotating pattern,
  // plus one long hold-off on request from the sender.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int          hold_left;
    int          phase_left;
    rx_mode_t    mode;
    logic [7:0]  pat;
    logic [31:0] w;
    hold_left  = 0;
    phase_left = 0;
    mode       = RX_FREE;
    pat        = 8'hff;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        mode       = rx_mode_t'($urandom_range(0, 2));
        w          = $urandom;
        pat        = (w[7:0] == 8'h00) ? 8'h01 : w[7:0];
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
          default: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer means the block has hung
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, due_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               n;
    int               burst;
    int               k;
    bit               held;
    bit               paused;
    logic [REC_W-1:0] rec_near_max;
    res_t             none;

    none         = '0;
    rec_near_max = ~record_of(24'hfffffe);

    // Directed table. The one and only first request after reset goes to a
    // record one below the maximum prefix: the prefix increments straight into
    // the all-ones value, so the closing read fails while the record is still
    // written back. Other rows cover the clear and load extremes, a record that
    // reads as all ones, the seed fold that leaves only the lsb, the secondary
    // copy taking over from a damaged or maximal primary, and a record with no
    // usable copy.
    dir_tab.push_back(mk_row(CMD_LOAD, rec_near_max, 24'h000000, 24'h000000, 1'b1,
                             mk_res(1'b1, '0, rec_near_max, 1'b0)));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'hffffff, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'hffffff, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_CLEAR, '0, 24'h000000, 24'h000000, 1'b1,
                             mk_res(1'b1, '0, {REC_W{1'b1}}, 1'b1)));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'hffffff, 24'hffffff, 1'b0, none));
    // stored all zeros decodes to all 0xff: nothing usable
    dir_tab.push_back(mk_row(CMD_LOAD, '0, 24'h000000, 24'h000000, 1'b1,
                             mk_res(1'b1, '0, '0, 1'b0)));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b1,
                             mk_res(1'b0, '0, '0, 1'b0)));
    // 0x33 folds to zero, so the reseeded prefix is just the lsb
    dir_tab.push_back(mk_row(CMD_RESEED, '0, 24'h330000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_RESEED, '0, 24'hffffff, 24'hffffff, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'hffffff, 24'hffffff, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_RESEED, '0, 24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    // damaged primary CRC, secondary good
    dir_tab.push_back(mk_row(CMD_LOAD,
                             ~{24'h123456, ~prefix_crc8(24'h123456), copy_of(24'h123456)},
                             24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    // primary at the maximum prefix with a valid CRC still loses
    dir_tab.push_back(mk_row(CMD_LOAD, ~{copy_of(24'hffffff), copy_of(24'h000010)},
                             24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    // both good and different: primary wins
    dir_tab.push_back(mk_row(CMD_LOAD, ~{copy_of(24'habcdef), copy_of(24'h111111)},
                             24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_LOAD, {REC_W{1'b1}}, 24'hffffff, 24'hffffff, 1'b1,
                             mk_res(1'b1, '0, {REC_W{1'b1}}, 1'b0)));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_LOAD, ~{copy_of(24'hfffffe), copy_of(24'hffffff)},
                             24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));
    // neither copy usable
    dir_tab.push_back(mk_row(CMD_LOAD, ~{32'h0000005a, 32'hffffff00},
                             24'h000000, 24'h000000, 1'b0, none));
    dir_tab.push_back(mk_row(CMD_REQ, '0, 24'h000000, 24'h000000, 1'b0, none));

    // synchronous reset held at the start, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_tab.size(); i++) begin
      offer(dir_tab[i]);
      if (i == 6) begin
        // sender stops until every outstanding result is back
        rest(1);
        wait_drained();
      end else begin
        rest($urandom_range(0, 2));
      end
    end

    // Random part: bursts of random length, random gaps (often none). Once the
    // receiver is asked for a long hold-off while a back-to-back burst keeps
    // coming, so the block fills and drops in_ready; once the sender waits for
    // everything to drain.
    n      = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(1, 16);
      if (!held && n >= RAND_ITEMS / 3) begin
        held     = 1'b1;
        hold_req = 1'b1;
        burst    = 12;
      end
      for (k = 0; k < burst && n < RAND_ITEMS; k++) begin
        offer(random_row());
        n++;
      end
      if (!paused && n >= (2 * RAND_ITEMS) / 3) begin
        paused = 1'b1;
        rest(1);
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        rest($urandom_range(1, 8));
      end
    end

    rest(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers, %0d of them counter requests, across loads, clears",
             n_in, n_req);
    $display("and reseeds; %0d results checked, %0d failed reads, %0d record write-backs.",
             n_checked, n_fail, n_wb);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/nccb_pkg.sv
sv/nccb_in_stage.sv
sv/nccb_core.sv
sv/nccb_out_stage.sv
sv/nonce_counter_with_crc_backup_top.sv
tb/nonce_counter_with_crc_backup_top_tb.sv
